[hdl/tfn_pkg.sv]
// Shared constants for the triangle face normal pipeline.
`default_nettype none

package tfn_pkg;

    // Number of vector components carried in parallel lanes.
    localparam int NUM_AXES = 3;

    // Lane index of each component.
    localparam int AXIS_X = 0;
    localparam int AXIS_Y = 1;
    localparam int AXIS_Z = 2;

endpackage

`default_nettype wire

[hdl/tfn_root_step.sv]
// One quotient bit of the length-normalizing root divider, for all three lanes.
`default_nettype none

module tfn_root_step #(
    parameter int LW  = 102,
    parameter int TW  = 128,
    parameter int PW  = 117,
    parameter int QW  = 15,
    parameter int DW  = 133,
    parameter int BIT = 0
) (
    input  wire logic                                 clk,
    input  wire logic                                 en,
    input  wire logic [LW-1:0]                        l_in,
    input  wire logic [tfn_pkg::NUM_AXES-1:0][TW-1:0] r_in,
    input  wire logic [tfn_pkg::NUM_AXES-1:0][PW-1:0] p_in,
    input  wire logic [tfn_pkg::NUM_AXES-1:0][QW-1:0] q_in,
    output logic      [LW-1:0]                        l_out,
    output logic      [tfn_pkg::NUM_AXES-1:0][TW-1:0] r_out,
    output logic      [tfn_pkg::NUM_AXES-1:0][PW-1:0] p_out,
    output logic      [tfn_pkg::NUM_AXES-1:0][QW-1:0] q_out
);

    logic [tfn_pkg::NUM_AXES-1:0][TW-1:0] r_next;
    logic [tfn_pkg::NUM_AXES-1:0][PW-1:0] p_next;
    logic [tfn_pkg::NUM_AXES-1:0][QW-1:0] q_next;
    logic [TW-1:0]                        r_reg [tfn_pkg::NUM_AXES];
    logic [PW-1:0]                        p_reg [tfn_pkg::NUM_AXES];
    logic [QW-1:0]                        q_reg [tfn_pkg::NUM_AXES];
    logic [LW-1:0]                        l_reg;

    // R holds T - q*q*L and P holds q*L. Setting bit BIT raises q*q*L by
    // D = 2*P*2^BIT + L*2^(2*BIT); the bit is kept when D still fits in R.
    always_comb
    begin
        logic [DW-1:0] d;
        logic [DW-1:0] r_ext;
        for (int k = 0; k < tfn_pkg::NUM_AXES; k++)
        begin
            d = ({{(DW-PW){1'b0}}, p_in[k]} << (BIT + 1))
              + ({{(DW-LW){1'b0}}, l_in} << (2 * BIT));
            r_ext = {{(DW-TW){1'b0}}, r_in[k]};
            if (d <= r_ext)
            begin
                r_next[k] = TW'(r_ext - d);
                p_next[k] = p_in[k] + ({{(PW-LW){1'b0}}, l_in} << BIT);
                q_next[k] = q_in[k] | (QW'(1) << BIT);
            end
            else
            begin
                r_next[k] = r_in[k];
                p_next[k] = p_in[k];
                q_next[k] = q_in[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            l_reg <= l_in;
            for (int k = 0; k < tfn_pkg::NUM_AXES; k++)
            begin
                r_reg[k] <= r_next[k];
                p_reg[k] <= p_next[k];
                q_reg[k] <= q_next[k];
            end
        end
    end

    always_comb
    begin
        l_out = l_reg;
        for (int k = 0; k < tfn_pkg::NUM_AXES; k++)
        begin
            r_out[k] = r_reg[k];
            p_out[k] = p_reg[k];
            q_out[k] = q_reg[k];
        end
    end

endmodule

`default_nettype wire

[hdl/triangle_face_normal.sv]
// Top level of the pipelined triangle unit face normal unit.
//
// Input channel (tri_valid / tri_stall) carries one triangle per item: three
// vertices a, b, c in signed Q12.12. Output channel (norm_valid /
// norm_stall) carries the unit normal of (b-a) x (c-a) in signed Q1.14, each
// component truncated toward zero, plus a degenerate flag. A zero cross
// product gives (0, 0, 1.0) with degenerate set.
//
// Throughput is one item per cycle while the receiver does not stall. The
// pipeline has seven stages of edge, cross product and squared length
// arithmetic, one stage per quotient bit of the root divider, and the
// output register. The divider is what sets the depth: each stage
// decides one quotient bit with one wide subtract and compare per lane.
//
// Reset clears every valid bit, so the pipeline comes up empty and accepts
// an item in the first cycle after reset is released. When the receiver
// stalls with a result waiting, the whole pipeline holds in place and
// tri_stall is raised; nothing is dropped or repeated. Bubbles in the
// pipeline are not squeezed out during a stall.
`default_nettype none

module triangle_face_normal #(
    parameter int COORD_WIDTH      = 24,
    parameter int NORMAL_FRAC_BITS = 14
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              tri_valid,
    output logic                                   tri_stall,
    input  wire logic signed [COORD_WIDTH-1:0]     a_x,
    input  wire logic signed [COORD_WIDTH-1:0]     a_y,
    input  wire logic signed [COORD_WIDTH-1:0]     a_z,
    input  wire logic signed [COORD_WIDTH-1:0]     b_x,
    input  wire logic signed [COORD_WIDTH-1:0]     b_y,
    input  wire logic signed [COORD_WIDTH-1:0]     b_z,
    input  wire logic signed [COORD_WIDTH-1:0]     c_x,
    input  wire logic signed [COORD_WIDTH-1:0]     c_y,
    input  wire logic signed [COORD_WIDTH-1:0]     c_z,
    output logic                                   norm_valid,
    input  wire logic                              norm_stall,
    output logic signed [NORMAL_FRAC_BITS+1:0]     n_x,
    output logic signed [NORMAL_FRAC_BITS+1:0]     n_y,
    output logic signed [NORMAL_FRAC_BITS+1:0]     n_z,
    output logic                                   degenerate
);

    localparam int NA  = tfn_pkg::NUM_AXES;
    localparam int CW  = COORD_WIDTH;
    localparam int F   = NORMAL_FRAC_BITS;
    localparam int OW  = F + 2;             // output width
    localparam int EW  = CW + 1;            // edge vector component
    localparam int PRW = 2 * EW;            // one cross product term
    localparam int CRW = PRW + 1;           // cross product component
    localparam int MW  = CRW - 1;           // magnitude of a component
    localparam int ML  = MW / 2;            // low half of the magnitude
    localparam int MH  = MW - ML;           // high half of the magnitude
    localparam int SQW = 2 * MW;            // squared component
    localparam int LW  = SQW + 2;           // squared length
    localparam int TW  = SQW + 2 * F;       // scaled squared component
    localparam int QW  = F + 1;             // quotient magnitude
    localparam int PW  = LW + QW;           // quotient times squared length
    localparam int DW  = LW + 2 * F + 3;    // trial increment
    localparam int NST = F + 1;             // divider stages

    // The whole pipeline moves together unless a finished result is held.
    logic en;
    assign en        = !(norm_valid && norm_stall);
    assign tri_stall = !en;

    // Vertices gathered into lanes.
    logic [NA-1:0][CW-1:0] va;
    logic [NA-1:0][CW-1:0] vb;
    logic [NA-1:0][CW-1:0] vc;

    always_comb
    begin
        va[tfn_pkg::AXIS_X] = a_x;
        va[tfn_pkg::AXIS_Y] = a_y;
        va[tfn_pkg::AXIS_Z] = a_z;
        vb[tfn_pkg::AXIS_X] = b_x;
        vb[tfn_pkg::AXIS_Y] = b_y;
        vb[tfn_pkg::AXIS_Z] = b_z;
        vc[tfn_pkg::AXIS_X] = c_x;
        vc[tfn_pkg::AXIS_Y] = c_y;
        vc[tfn_pkg::AXIS_Z] = c_z;
    end

    // Stage 1: edge vectors.
    logic [NA-1:0][EW-1:0] e1_next, e2_next, e1_reg, e2_reg;
    logic                  v1_reg;

    always_comb
    begin
        for (int k = 0; k < NA; k++)
        begin
            e1_next[k] = {vb[k][CW-1], vb[k]} - {va[k][CW-1], va[k]};
            e2_next[k] = {vc[k][CW-1], vc[k]} - {va[k][CW-1], va[k]};
        end
    end

    // Stage 2: the six signed products of the cross product.
    logic [NA-1:0][PRW-1:0] pa_next, pb_next, pa_reg, pb_reg;
    logic                   v2_reg;

    always_comb
    begin
        logic signed [EW-1:0] x1, x2, y1, y2;
        for (int k = 0; k < NA; k++)
        begin
            x1 = $signed(e1_reg[(k+1)%NA]);
            y1 = $signed(e2_reg[(k+2)%NA]);
            x2 = $signed(e1_reg[(k+2)%NA]);
            y2 = $signed(e2_reg[(k+1)%NA]);
            pa_next[k] = PRW'(x1 * y1);
            pb_next[k] = PRW'(x2 * y2);
        end
    end

    // Stage 3: cross product components.
    logic [NA-1:0][CRW-1:0] cr_next, cr_reg;
    logic                   v3_reg;

    always_comb
    begin
        for (int k = 0; k < NA; k++)
        begin
            cr_next[k] = {pa_reg[k][PRW-1], pa_reg[k]} - {pb_reg[k][PRW-1], pb_reg[k]};
        end
    end

    // Stage 4: sign and magnitude.
    logic [NA-1:0][MW-1:0] mag_next, mag_reg;
    logic [NA-1:0]         neg_next, neg4_reg;
    logic                  v4_reg;

    always_comb
    begin
        logic [CRW-1:0] abs_v;
        for (int k = 0; k < NA; k++)
        begin
            neg_next[k] = cr_reg[k][CRW-1];
            abs_v       = neg_next[k] ? (CRW'(0) - cr_reg[k]) : cr_reg[k];
            mag_next[k] = abs_v[MW-1:0];
        end
    end

    // Stage 5: partial products of each squared magnitude, split in halves.
    logic [NA-1:0][2*MH-1:0]  hh_next, hh_reg;
    logic [NA-1:0][MH+ML-1:0] hl_next, hl_reg;
    logic [NA-1:0][2*ML-1:0]  ll_next, ll_reg;
    logic [NA-1:0]            neg5_reg;
    logic                     zero_next, zero5_reg;
    logic                     v5_reg;

    always_comb
    begin
        logic [MH-1:0] mh;
        logic [ML-1:0] ml;
        zero_next = 1'b1;
        for (int k = 0; k < NA; k++)
        begin
            mh         = mag_reg[k][MW-1:ML];
            ml         = mag_reg[k][ML-1:0];
            hh_next[k] = (2*MH)'(mh * mh);
            hl_next[k] = (MH+ML)'(mh * ml);
            ll_next[k] = (2*ML)'(ml * ml);
            if (mag_reg[k] != '0)
            begin
                zero_next = 1'b0;
            end
        end
    end

    // Stage 6: squared magnitudes.
    logic [NA-1:0][SQW-1:0] sq_next, sq_reg;
    logic [NA-1:0]          neg6_reg;
    logic                   zero6_reg;
    logic                   v6_reg;

    always_comb
    begin
        for (int k = 0; k < NA; k++)
        begin
            sq_next[k] = ({{(SQW-2*MH){1'b0}}, hh_reg[k]} << (2 * ML))
                       + ({{(SQW-MH-ML){1'b0}}, hl_reg[k]} << (ML + 1))
                       + {{(SQW-2*ML){1'b0}}, ll_reg[k]};
        end
    end

    // Stage 7: squared length and the scaled dividends.
    logic [LW-1:0]         len2_next, len2_reg;
    logic [NA-1:0][TW-1:0] t_next, t_reg;
    logic [NA-1:0]         neg7_reg;
    logic                  zero7_reg;
    logic                  v7_reg;

    always_comb
    begin
        len2_next = '0;
        for (int k = 0; k < NA; k++)
        begin
            len2_next = len2_next + {{(LW-SQW){1'b0}}, sq_reg[k]};
            t_next[k] = {sq_reg[k], {(2*F){1'b0}}};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= tri_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e1_reg    <= e1_next;
            e2_reg    <= e2_next;
            pa_reg    <= pa_next;
            pb_reg    <= pb_next;
            cr_reg    <= cr_next;
            mag_reg   <= mag_next;
            neg4_reg  <= neg_next;
            hh_reg    <= hh_next;
            hl_reg    <= hl_next;
            ll_reg    <= ll_next;
            neg5_reg  <= neg4_reg;
            zero5_reg <= zero_next;
            sq_reg    <= sq_next;
            neg6_reg  <= neg5_reg;
            zero6_reg <= zero5_reg;
            len2_reg  <= len2_next;
            t_reg     <= t_next;
            neg7_reg  <= neg6_reg;
            zero7_reg <= zero6_reg;
        end
    end

    // Root divider: one quotient bit per stage, most significant first.
    logic [NST:0][LW-1:0]         l_pipe;
    logic [NST:0][NA-1:0][TW-1:0] r_pipe;
    logic [NST:0][NA-1:0][PW-1:0] p_pipe;
    logic [NST:0][NA-1:0][QW-1:0] q_pipe;

    assign l_pipe[0] = len2_reg;
    assign r_pipe[0] = t_reg;
    assign p_pipe[0] = '0;
    assign q_pipe[0] = '0;

    for (genvar j = 0; j < NST; j++)
    begin : g_step
        tfn_root_step #(
            .LW  (LW),
            .TW  (TW),
            .PW  (PW),
            .QW  (QW),
            .DW  (DW),
            .BIT (F - j)
        ) u_step (
            .clk   (clk),
            .en    (en),
            .l_in  (l_pipe[j]),
            .r_in  (r_pipe[j]),
            .p_in  (p_pipe[j]),
            .q_in  (q_pipe[j]),
            .l_out (l_pipe[j+1]),
            .r_out (r_pipe[j+1]),
            .p_out (p_pipe[j+1]),
            .q_out (q_pipe[j+1])
        );
    end

    // Sign, degenerate flag and valid travel alongside the divider.
    logic [NST-1:0][NA-1:0] neg_pipe_reg;
    logic [NST-1:0]         zero_pipe_reg;
    logic [NST-1:0]         vd_pipe_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vd_pipe_reg <= '0;
        end
        else if (en)
        begin
            vd_pipe_reg <= {vd_pipe_reg[NST-2:0], v7_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg_pipe_reg  <= {neg_pipe_reg[NST-2:0], neg7_reg};
            zero_pipe_reg <= {zero_pipe_reg[NST-2:0], zero7_reg};
        end
    end

    // Output register: apply the sign, or the default normal.
    logic [NA-1:0][OW-1:0] n_next, n_reg;
    logic                  degen_reg;
    logic                  out_valid_reg;

    always_comb
    begin
        logic [OW-1:0] qm;
        for (int k = 0; k < NA; k++)
        begin
            qm = {1'b0, q_pipe[NST][k]};
            n_next[k] = neg_pipe_reg[NST-1][k] ? (OW'(0) - qm) : qm;
        end
        if (zero_pipe_reg[NST-1])
        begin
            n_next[tfn_pkg::AXIS_X] = '0;
            n_next[tfn_pkg::AXIS_Y] = '0;
            n_next[tfn_pkg::AXIS_Z] = OW'(1) << F;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= vd_pipe_reg[NST-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg     <= n_next;
            degen_reg <= zero_pipe_reg[NST-1];
        end
    end

    assign norm_valid = out_valid_reg;
    assign n_x        = n_reg[tfn_pkg::AXIS_X];
    assign n_y        = n_reg[tfn_pkg::AXIS_Y];
    assign n_z        = n_reg[tfn_pkg::AXIS_Z];
    assign degenerate = degen_reg;

endmodule

`default_nettype wire
